[hw/rtl/rti_pkg.sv]
// shared constants and types for the ray / triangle intersection pipeline
`timescale 1ns / 1ps
`default_nettype none

package rti_pkg;

    localparam int COORD_BITS_DEF  = 21;
    localparam int RESULT_BITS_DEF = 32;
    localparam int THR_BITS        = 20;
    localparam int T_BITS          = 32;
    localparam int VEC_BITS        = 63;
    localparam int QUO_BITS        = 33;
    localparam int FRAC_SHIFT      = 16;
    localparam int OUT_SHIFT       = 6;
    localparam int PROD_SHIFT      = 10;
    localparam int ADDR_BITS       = 3;
    localparam int DATA_BITS       = 32;

    localparam logic                REG_THR_IDX = 1'b0;
    localparam logic [THR_BITS-1:0] THR_RESET   = 20'd1;

    typedef struct packed {
        logic [VEC_BITS-1:0]      org;
        logic [VEC_BITS-1:0]      dir;
        logic signed [T_BITS-1:0] tlo;
        logic signed [T_BITS-1:0] thi;
        logic                     miss;
        logic                     tneg;
    } side_t;

endpackage

`default_nettype wire

[hw/rtl/rti_geom.sv]
// edges, cross products and the four exact dot products
`timescale 1ns / 1ps
`default_nettype none

module rti_geom #(
    parameter int COORD_BITS = rti_pkg::COORD_BITS_DEF,
    localparam int WB = 3 * COORD_BITS + 6
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  en,
    input  logic                                  in_valid,
    input  logic [rti_pkg::VEC_BITS-1:0]          ray_origin,
    input  logic [rti_pkg::VEC_BITS-1:0]          ray_direction,
    input  logic [rti_pkg::VEC_BITS-1:0]          vertex_a,
    input  logic [rti_pkg::VEC_BITS-1:0]          vertex_b,
    input  logic [rti_pkg::VEC_BITS-1:0]          vertex_c,
    input  logic signed [rti_pkg::T_BITS-1:0]     t_lower,
    input  logic signed [rti_pkg::T_BITS-1:0]     t_upper,
    output logic                                  out_valid,
    output rti_pkg::side_t                        out_side,
    output logic signed [WB-1:0]                  det,
    output logic signed [WB-1:0]                  nu,
    output logic signed [WB-1:0]                  nv,
    output logic signed [WB-1:0]                  nt
);

    localparam int CB = COORD_BITS;
    localparam int EB = CB + 1;
    localparam int HB = 2 * CB + 2;
    localparam int QB = 2 * CB + 3;
    localparam int LB = CB + 2;
    localparam int NS = 5;

    logic signed [CB-1:0] o_u [3];
    logic signed [CB-1:0] d_u [3];
    logic signed [CB-1:0] a_u [3];
    logic signed [CB-1:0] b_u [3];
    logic signed [CB-1:0] c_u [3];

    logic signed [EB-1:0] e1_next [3];
    logic signed [EB-1:0] e2_next [3];
    logic signed [EB-1:0] s_next  [3];
    logic signed [EB-1:0] e1_reg  [3];
    logic signed [EB-1:0] e2_reg  [3];
    logic signed [EB-1:0] s_reg   [3];
    logic signed [CB-1:0] d1_reg  [3];

    logic signed [HB-1:0] h_next  [3];
    logic signed [QB-1:0] q_next  [3];
    logic signed [HB-1:0] h_reg   [3];
    logic signed [QB-1:0] q_reg   [3];
    logic signed [CB-1:0] d2_reg  [3];
    logic signed [EB-1:0] e1b_reg [3];
    logic signed [EB-1:0] e2b_reg [3];
    logic signed [EB-1:0] sb_reg  [3];

    logic signed [EB-1:0] oa [4][3];
    logic signed [QB-1:0] ob [4][3];
    logic signed [WB-1:0] ph_next [4][3];
    logic signed [WB-1:0] pl_next [4][3];
    logic signed [WB-1:0] ph_reg  [4][3];
    logic signed [WB-1:0] pl_reg  [4][3];
    logic signed [WB-1:0] tm_next [4][3];
    logic signed [WB-1:0] tm_reg  [4][3];
    logic signed [WB-1:0] sum_next [4];
    logic signed [WB-1:0] sum_reg  [4];

    logic [NS-1:0]  v_reg;
    rti_pkg::side_t side_reg [NS];
    rti_pkg::side_t side_next;

    // unpack and edge vectors
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            o_u[i] = ray_origin[i*CB +: CB];
            d_u[i] = ray_direction[i*CB +: CB];
            a_u[i] = vertex_a[i*CB +: CB];
            b_u[i] = vertex_b[i*CB +: CB];
            c_u[i] = vertex_c[i*CB +: CB];
            e1_next[i] = EB'(b_u[i]) - EB'(a_u[i]);
            e2_next[i] = EB'(c_u[i]) - EB'(a_u[i]);
            s_next[i]  = EB'(o_u[i]) - EB'(a_u[i]);
        end
        side_next.org  = ray_origin;
        side_next.dir  = ray_direction;
        side_next.tlo  = t_lower;
        side_next.thi  = t_upper;
        side_next.miss = 1'b0;
        side_next.tneg = 1'b0;
    end

    // h = dir x edge2, q = s x edge1
    always_comb
    begin
        h_next[0] = HB'(d1_reg[1]) * HB'(e2_reg[2]) - HB'(d1_reg[2]) * HB'(e2_reg[1]);
        h_next[1] = HB'(d1_reg[2]) * HB'(e2_reg[0]) - HB'(d1_reg[0]) * HB'(e2_reg[2]);
        h_next[2] = HB'(d1_reg[0]) * HB'(e2_reg[1]) - HB'(d1_reg[1]) * HB'(e2_reg[0]);
        q_next[0] = QB'(s_reg[1]) * QB'(e1_reg[2]) - QB'(s_reg[2]) * QB'(e1_reg[1]);
        q_next[1] = QB'(s_reg[2]) * QB'(e1_reg[0]) - QB'(s_reg[0]) * QB'(e1_reg[2]);
        q_next[2] = QB'(s_reg[0]) * QB'(e1_reg[1]) - QB'(s_reg[1]) * QB'(e1_reg[0]);
    end

    // dot products split into high and low partial products
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            oa[0][j] = e1b_reg[j];
            ob[0][j] = QB'(h_reg[j]);
            oa[1][j] = sb_reg[j];
            ob[1][j] = QB'(h_reg[j]);
            oa[2][j] = EB'(d2_reg[j]);
            ob[2][j] = q_reg[j];
            oa[3][j] = e2b_reg[j];
            ob[3][j] = q_reg[j];
        end
        for (int k = 0; k < 4; k++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                ph_next[k][j] = WB'(oa[k][j]) * WB'($signed(ob[k][j][QB-1:LB]));
                pl_next[k][j] = WB'(oa[k][j]) * WB'($signed({1'b0, ob[k][j][LB-1:0]}));
                tm_next[k][j] = (ph_reg[k][j] <<< LB) + pl_reg[k][j];
            end
            sum_next[k] = tm_reg[k][0] + tm_reg[k][1] + tm_reg[k][2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[NS-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_next;
            for (int n = 1; n < NS; n++)
            begin
                side_reg[n] <= side_reg[n-1];
            end
            for (int i = 0; i < 3; i++)
            begin
                e1_reg[i]  <= e1_next[i];
                e2_reg[i]  <= e2_next[i];
                s_reg[i]   <= s_next[i];
                d1_reg[i]  <= d_u[i];
                h_reg[i]   <= h_next[i];
                q_reg[i]   <= q_next[i];
                d2_reg[i]  <= d1_reg[i];
                e1b_reg[i] <= e1_reg[i];
                e2b_reg[i] <= e2_reg[i];
                sb_reg[i]  <= s_reg[i];
            end
            for (int k = 0; k < 4; k++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    ph_reg[k][j] <= ph_next[k][j];
                    pl_reg[k][j] <= pl_next[k][j];
                    tm_reg[k][j] <= tm_next[k][j];
                end
                sum_reg[k] <= sum_next[k];
            end
        end
    end

    assign out_valid = v_reg[NS-1];
    assign out_side  = side_reg[NS-1];
    assign det       = sum_reg[0];
    assign nu        = sum_reg[1];
    assign nv        = sum_reg[2];
    assign nt        = sum_reg[3];

endmodule

`default_nettype wire

[hw/rtl/rti_test.sv]
// sign normalization, parallel and barycentric rejection, quotient range check
`timescale 1ns / 1ps
`default_nettype none

module rti_test #(
    parameter int COORD_BITS = rti_pkg::COORD_BITS_DEF,
    localparam int WB = 3 * COORD_BITS + 6
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             en,
    input  logic                             in_valid,
    input  rti_pkg::side_t                   in_side,
    input  logic signed [WB-1:0]             det,
    input  logic signed [WB-1:0]             nu,
    input  logic signed [WB-1:0]             nv,
    input  logic signed [WB-1:0]             nt,
    input  logic [rti_pkg::THR_BITS-1:0]     thr,
    output logic                             out_valid,
    output rti_pkg::side_t                   out_side,
    output logic [WB-1:0]                    dm,
    output logic [WB-1:0]                    mnt
);

    localparam int OVS = rti_pkg::QUO_BITS - rti_pkg::FRAC_SHIFT;

    logic [WB-1:0]        dm_next;
    logic [WB-1:0]        mnt_next;
    logic signed [WB-1:0] nu_next;
    logic signed [WB-1:0] nv_next;
    logic [WB-1:0]        dm_reg;
    logic [WB-1:0]        mnt_reg;
    logic signed [WB-1:0] nu_reg;
    logic signed [WB-1:0] nv_reg;
    rti_pkg::side_t       side1_reg;
    rti_pkg::side_t       side1_next;

    logic signed [WB:0]   uv_sum;
    logic signed [WB:0]   dm_s;
    logic                 reject;
    rti_pkg::side_t       side2_next;
    rti_pkg::side_t       side2_reg;
    logic [WB-1:0]        dm2_reg;
    logic [WB-1:0]        mnt2_reg;
    logic [1:0]           v_reg;

    always_comb
    begin
        dm_next  = det[WB-1] ? WB'(-det) : WB'(det);
        mnt_next = nt[WB-1] ? WB'(-nt) : WB'(nt);
        nu_next  = det[WB-1] ? -nu : nu;
        nv_next  = det[WB-1] ? -nv : nv;
        side1_next      = in_side;
        side1_next.tneg = nt[WB-1] ^ det[WB-1];
    end

    always_comb
    begin
        uv_sum = (WB+1)'(nu_reg) + (WB+1)'(nv_reg);
        dm_s   = $signed({1'b0, dm_reg});
        reject = (dm_reg <= {{(WB-rti_pkg::THR_BITS){1'b0}}, thr})
               || nu_reg[WB-1]
               || ((WB+1)'(nu_reg) > dm_s)
               || nv_reg[WB-1]
               || (uv_sum > dm_s)
               // quotient would need more bits than the window can ever hold
               || ({{OVS{1'b0}}, mnt_reg} >= {dm_reg, {OVS{1'b0}}});
        side2_next      = side1_reg;
        side2_next.miss = side1_reg.miss | reject;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dm_reg    <= dm_next;
            mnt_reg   <= mnt_next;
            nu_reg    <= nu_next;
            nv_reg    <= nv_next;
            side1_reg <= side1_next;
            dm2_reg   <= dm_reg;
            mnt2_reg  <= mnt_reg;
            side2_reg <= side2_next;
        end
    end

    assign out_valid = v_reg[1];
    assign out_side  = side2_reg;
    assign dm        = dm2_reg;
    assign mnt       = mnt2_reg;

endmodule

`default_nettype wire

[hw/rtl/rti_div.sv]
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
`default_nettype none

module rti_div #(
    parameter int COORD_BITS = rti_pkg::COORD_BITS_DEF,
    localparam int WB = 3 * COORD_BITS + 6,
    localparam int RW = WB + rti_pkg::FRAC_SHIFT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             en,
    input  logic                             in_valid,
    input  rti_pkg::side_t                   in_side,
    input  logic [WB-1:0]                    dm,
    input  logic [WB-1:0]                    mnt,
    output logic                             out_valid,
    output rti_pkg::side_t                   out_side,
    output logic [rti_pkg::QUO_BITS-1:0]     quo,
    output logic [RW-1:0]                    rem
);

    localparam int QN = rti_pkg::QUO_BITS;
    localparam int XW = WB + QN;

    logic [RW-1:0]  r_src  [QN];
    logic [WB-1:0]  d_src  [QN];
    logic [QN-1:0]  q_src  [QN];
    logic [RW-1:0]  r_next [QN];
    logic [QN-1:0]  q_next [QN];
    logic [XW-1:0]  dsh    [QN];
    logic [XW-1:0]  rx     [QN];
    logic [RW-1:0]  r_reg  [QN];
    logic [WB-1:0]  d_reg  [QN];
    logic [QN-1:0]  q_reg  [QN];
    rti_pkg::side_t side_reg [QN];
    logic [QN-1:0]  v_reg;

    always_comb
    begin
        r_src[0] = {mnt, {rti_pkg::FRAC_SHIFT{1'b0}}};
        d_src[0] = dm;
        q_src[0] = '0;
        for (int k = 1; k < QN; k++)
        begin
            r_src[k] = r_reg[k-1];
            d_src[k] = d_reg[k-1];
            q_src[k] = q_reg[k-1];
        end
        // stage k settles quotient bit QN-1-k
        for (int k = 0; k < QN; k++)
        begin
            dsh[k] = XW'(d_src[k]) << (QN - 1 - k);
            rx[k]  = XW'(r_src[k]);
            if (rx[k] >= dsh[k])
            begin
                r_next[k] = RW'(rx[k] - dsh[k]);
                q_next[k] = q_src[k] | (QN'(1) << (QN - 1 - k));
            end
            else
            begin
                r_next[k] = r_src[k];
                q_next[k] = q_src[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[QN-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= in_side;
            for (int k = 1; k < QN; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
            for (int k = 0; k < QN; k++)
            begin
                r_reg[k] <= r_next[k];
                d_reg[k] <= d_src[k];
                q_reg[k] <= q_next[k];
            end
        end
    end

    assign out_valid = v_reg[QN-1];
    assign out_side  = side_reg[QN-1];
    assign quo       = q_reg[QN-1];
    assign rem       = r_reg[QN-1];

endmodule

`default_nettype wire

[hw/rtl/rti_point.sv]
// signed distance, window test, hit point and saturated output register
`timescale 1ns / 1ps
`default_nettype none

module rti_point #(
    parameter int COORD_BITS  = rti_pkg::COORD_BITS_DEF,
    parameter int RESULT_BITS = rti_pkg::RESULT_BITS_DEF,
    localparam int RW = 3 * COORD_BITS + 6 + rti_pkg::FRAC_SHIFT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             en,
    input  logic                             in_valid,
    input  rti_pkg::side_t                   in_side,
    input  logic [rti_pkg::QUO_BITS-1:0]     quo,
    input  logic [RW-1:0]                    rem,
    output logic                             out_valid,
    output logic                             hit,
    output logic signed [RESULT_BITS-1:0]    hit_distance,
    output logic signed [RESULT_BITS-1:0]    hit_x,
    output logic signed [RESULT_BITS-1:0]    hit_y,
    output logic signed [RESULT_BITS-1:0]    hit_z
);

    localparam int CB   = COORD_BITS;
    localparam int RB   = RESULT_BITS;
    localparam int TB   = rti_pkg::T_BITS;
    localparam int FB   = rti_pkg::QUO_BITS + 2;
    localparam int PW   = CB + TB;
    localparam int SUMW = PW - rti_pkg::PROD_SHIFT + 1;
    localparam int MW   = (SUMW > RB) ? SUMW : RB;
    localparam int SW   = ((MW > TB) ? MW : TB) + 1;
    localparam logic signed [SW-1:0] MAXV = (SW'(1) <<< (RB - 1)) - SW'(1);
    localparam logic signed [SW-1:0] MINV = -MAXV - SW'(1);

    function automatic logic [RB-1:0] sat_res(input logic signed [SW-1:0] v);
        logic [RB-1:0] r;
        if (v > MAXV)
        begin
            r = MAXV[RB-1:0];
        end
        else if (v < MINV)
        begin
            r = MINV[RB-1:0];
        end
        else
        begin
            r = v[RB-1:0];
        end
        return r;
    endfunction

    logic                 inexact_next;
    logic signed [FB-1:0] f_next;
    logic signed [FB-1:0] f_reg;
    logic                 inexact_reg;
    rti_pkg::side_t       side1_reg;

    logic signed [FB-1:0] tlo_x;
    logic signed [FB-1:0] thi_x;
    logic                 hit_next;
    logic                 hit2_reg;
    logic signed [TB-1:0] t2_reg;
    rti_pkg::side_t       side2_reg;

    logic signed [CB-1:0] d_u [3];
    logic signed [PW-1:0] pd_next [3];
    logic signed [PW-1:0] pd_reg  [3];
    logic                 hit3_reg;
    logic signed [TB-1:0] t3_reg;
    logic [rti_pkg::VEC_BITS-1:0] org3_reg;

    logic signed [CB-1:0]   o_u [3];
    logic signed [SUMW-1:0] pt  [3];
    logic                   hit_reg;
    logic [RB-1:0]          dist_reg;
    logic [RB-1:0]          pt_reg [3];
    logic [3:0]             v_reg;

    // floor quotient with sign restored
    always_comb
    begin
        inexact_next = |rem;
        f_next = in_side.tneg ? -$signed(FB'(quo)) - $signed(FB'(inexact_next))
                              : $signed(FB'(quo));
    end

    // open window, compared against the exact distance
    always_comb
    begin
        tlo_x    = FB'(side1_reg.tlo);
        thi_x    = FB'(side1_reg.thi);
        hit_next = !side1_reg.miss
                && ((f_reg > tlo_x) || ((f_reg == tlo_x) && inexact_reg))
                && (f_reg < thi_x);
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            d_u[i]     = side2_reg.dir[i*CB +: CB];
            pd_next[i] = PW'(d_u[i]) * PW'(t2_reg);
            o_u[i]     = org3_reg[i*CB +: CB];
            pt[i]      = (SUMW'(o_u[i]) <<< rti_pkg::OUT_SHIFT)
                       + SUMW'(pd_reg[i] >>> rti_pkg::PROD_SHIFT);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_reg       <= f_next;
            inexact_reg <= inexact_next;
            side1_reg   <= in_side;
            hit2_reg    <= hit_next;
            t2_reg      <= f_reg[TB-1:0];
            side2_reg   <= side1_reg;
            hit3_reg    <= hit2_reg;
            t3_reg      <= t2_reg;
            org3_reg    <= side2_reg.org;
            for (int i = 0; i < 3; i++)
            begin
                pd_reg[i] <= pd_next[i];
            end
            hit_reg  <= hit3_reg;
            dist_reg <= hit3_reg ? sat_res(SW'(t3_reg)) : '0;
            for (int i = 0; i < 3; i++)
            begin
                pt_reg[i] <= hit3_reg ? sat_res(SW'(pt[i])) : '0;
            end
        end
    end

    assign out_valid    = v_reg[3];
    assign hit          = hit_reg;
    assign hit_distance = $signed(dist_reg);
    assign hit_x        = $signed(pt_reg[0]);
    assign hit_y        = $signed(pt_reg[1]);
    assign hit_z        = $signed(pt_reg[2]);

endmodule

`default_nettype wire

[hw/rtl/ray_triangle_intersection.sv]
// top level of the ray / triangle intersection pipeline with its register port
`timescale 1ns / 1ps
`default_nettype none

// Moller-Trumbore ray / triangle test, one request per clock. Every request
// carries a ray, three corners (three signed Q10.10 coordinates each, x in the
// low bits) and an open distance window. Edges, cross products and the four
// dot products are exact integers; the only rounding is the Q16.16 distance,
// taken toward minus infinity, and the hit point origin + dir * t, whose
// product is floored to 16 fraction bits. Results are saturated to
// RESULT_BITS; a miss returns all zeros. A request passes through 5 geometry
// stages, 2 rejection stages, one divider stage per quotient bit (33), and 4
// stages for distance, window, hit point multiply and the output register.
// The pipeline takes a new request every cycle; it holds as a whole only
// while a result sits in the output register and the consumer stalls it.
// parallel_threshold sits at byte address 0 and resets to 1; the user
// must see that it is written only while the pipeline is empty, as the
// block itself does not enforce it.
module ray_triangle_intersection #(
    parameter int COORD_BITS  = rti_pkg::COORD_BITS_DEF,
    parameter int RESULT_BITS = rti_pkg::RESULT_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // register port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [rti_pkg::ADDR_BITS-1:0]         paddr,
    input  logic [rti_pkg::DATA_BITS-1:0]         pwdata,
    output logic [rti_pkg::DATA_BITS-1:0]         prdata,
    output logic                                  pready,
    // request channel
    input  logic                                  req_valid,
    output logic                                  req_stall,
    input  logic [rti_pkg::VEC_BITS-1:0]          ray_origin,
    input  logic [rti_pkg::VEC_BITS-1:0]          ray_direction,
    input  logic [rti_pkg::VEC_BITS-1:0]          vertex_a,
    input  logic [rti_pkg::VEC_BITS-1:0]          vertex_b,
    input  logic [rti_pkg::VEC_BITS-1:0]          vertex_c,
    input  logic signed [rti_pkg::T_BITS-1:0]     t_lower,
    input  logic signed [rti_pkg::T_BITS-1:0]     t_upper,
    // result channel
    output logic                                  res_valid,
    input  logic                                  res_stall,
    output logic                                  hit,
    output logic signed [RESULT_BITS-1:0]         hit_distance,
    output logic signed [RESULT_BITS-1:0]         hit_x,
    output logic signed [RESULT_BITS-1:0]         hit_y,
    output logic signed [RESULT_BITS-1:0]         hit_z
);

    localparam int WB = 3 * COORD_BITS + 6;
    localparam int RW = WB + rti_pkg::FRAC_SHIFT;

    logic [rti_pkg::THR_BITS-1:0] thr_reg;
    logic                         thr_sel;
    logic                         en;

    logic                  g_valid;
    rti_pkg::side_t        g_side;
    logic signed [WB-1:0]  g_det;
    logic signed [WB-1:0]  g_nu;
    logic signed [WB-1:0]  g_nv;
    logic signed [WB-1:0]  g_nt;

    logic                  t_valid;
    rti_pkg::side_t        t_side;
    logic [WB-1:0]         t_dm;
    logic [WB-1:0]         t_mnt;

    logic                  d_valid;
    rti_pkg::side_t        d_side;
    logic [rti_pkg::QUO_BITS-1:0] d_quo;
    logic [RW-1:0]         d_rem;

    // register port: single register, word index taken from paddr above the byte bits
    assign pready  = 1'b1;
    assign thr_sel = (paddr[rti_pkg::ADDR_BITS-1] == rti_pkg::REG_THR_IDX);
    assign prdata  = thr_sel ? rti_pkg::DATA_BITS'(thr_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= rti_pkg::THR_RESET;
        end
        else if (psel && penable && pwrite && pready && thr_sel)
        begin
            thr_reg <= pwdata[rti_pkg::THR_BITS-1:0];
        end
    end

    // whole pipeline advances unless a finished result is held at the output
    assign en        = !(res_valid && res_stall);
    assign req_stall = !en;

    // edges, cross products, dot products
    rti_geom #(
        .COORD_BITS (COORD_BITS)
    ) u_geom (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .in_valid      (req_valid),
        .ray_origin    (ray_origin),
        .ray_direction (ray_direction),
        .vertex_a      (vertex_a),
        .vertex_b      (vertex_b),
        .vertex_c      (vertex_c),
        .t_lower       (t_lower),
        .t_upper       (t_upper),
        .out_valid     (g_valid),
        .out_side      (g_side),
        .det           (g_det),
        .nu            (g_nu),
        .nv            (g_nv),
        .nt            (g_nt)
    );

    // parallel and barycentric rejection, divider operands
    rti_test #(
        .COORD_BITS (COORD_BITS)
    ) u_test (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (g_valid),
        .in_side   (g_side),
        .det       (g_det),
        .nu        (g_nu),
        .nv        (g_nv),
        .nt        (g_nt),
        .thr       (thr_reg),
        .out_valid (t_valid),
        .out_side  (t_side),
        .dm        (t_dm),
        .mnt       (t_mnt)
    );

    // |nt| * 2^16 / |det|
    rti_div #(
        .COORD_BITS (COORD_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (t_valid),
        .in_side   (t_side),
        .dm        (t_dm),
        .mnt       (t_mnt),
        .out_valid (d_valid),
        .out_side  (d_side),
        .quo       (d_quo),
        .rem       (d_rem)
    );

    // distance, window, hit point and output register
    rti_point #(
        .COORD_BITS  (COORD_BITS),
        .RESULT_BITS (RESULT_BITS)
    ) u_point (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .in_valid     (d_valid),
        .in_side      (d_side),
        .quo          (d_quo),
        .rem          (d_rem),
        .out_valid    (res_valid),
        .hit          (hit),
        .hit_distance (hit_distance),
        .hit_x        (hit_x),
        .hit_y        (hit_y),
        .hit_z        (hit_z)
    );

endmodule

`default_nettype wire
